// ===== rtl/cpid_pkg.sv =====
package cpid_pkg;

   // Number formats
   localparam int FRAC_BITS = 12;
   localparam int SUM_WIDTH = 32;
   localparam int SIG_W     = 18;
   localparam int GAIN_W    = 16;
   localparam int LIM_W     = 17;
   localparam int ERR_W     = SIG_W + 1;
   localparam int MAG_W     = ERR_W + 1;
   localparam int ACC_W     = SIG_W + 7;

   // Axes
   localparam int NUM_AXES = 3;
   localparam int AXIS_W   = 2;

   // Register port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = LIM_W;

   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_KP  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_KI  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_KD  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_RATE_KP   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_RATE_KI   = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_RATE_KD   = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_TILT_LIM  = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_YAW_LIM   = CSR_IDX_W'(7);

   // Register reset values
   localparam logic signed [GAIN_W-1:0] RST_ANGLE_KP = GAIN_W'(18432);
   localparam logic signed [GAIN_W-1:0] RST_ANGLE_KI = GAIN_W'(0);
   localparam logic signed [GAIN_W-1:0] RST_ANGLE_KD = GAIN_W'(0);
   localparam logic signed [GAIN_W-1:0] RST_RATE_KP  = GAIN_W'(11059);
   localparam logic signed [GAIN_W-1:0] RST_RATE_KI  = GAIN_W'(4096);
   localparam logic signed [GAIN_W-1:0] RST_RATE_KD  = -GAIN_W'(41);
   localparam logic [LIM_W-1:0]         RST_TILT_LIM = LIM_W'(25600);
   localparam logic [LIM_W-1:0]         RST_YAW_LIM  = LIM_W'(9216);

   // Windows and bounds, rounded to nearest at FRAC_BITS
   localparam longint WIN_TILT   = ((longint'(349) << FRAC_BITS) + 5000) / 10000;
   localparam longint WIN_YAW    = ((longint'(1396) << FRAC_BITS) + 5000) / 10000;
   localparam longint WIN_RATE   = ((longint'(174532) << FRAC_BITS) + 500000) / 1000000;
   localparam longint RATE_BOUND = ((longint'(87266) << FRAC_BITS) + 50000) / 100000;

   // Integral scaling: divide by ticks per second through a reciprocal
   localparam int     TICK_DIV  = 100;
   localparam int     DIV_SHIFT = 31;
   localparam longint DIV_MAGIC = ((longint'(1) << DIV_SHIFT) + TICK_DIV - 1) / TICK_DIV;
   // integral pre-saturation, an exact multiple of TICK_DIV past any bound
   localparam longint ISAT      = longint'(TICK_DIV) << (SIG_W - 1);
   localparam int     Z_W       = $clog2(2 * ISAT + 1);
   localparam int     Q_W       = SIG_W + 1;

   // Shared multiplier
   localparam int MUL_A_W = Z_W + 1;
   localparam int MUL_B_W = SUM_WIDTH + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Loop sequencer steps
   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_ERR  = 9'b000000010,
      S_MP   = 9'b000000100,
      S_MI   = 9'b000001000,
      S_MZ   = 9'b000010000,
      S_MQ   = 9'b000100000,
      S_MD   = 9'b001000000,
      S_FIN  = 9'b010000000,
      S_POST = 9'b100000000
   } step_type;

   typedef struct packed {
      step_type          step;
      logic [AXIS_W-1:0] axis;
      logic              inner;
   } ctl_type;

endpackage

// ===== rtl/cpid_mul.sv =====
module cpid_mul (
   input  logic                                clock,
   input  logic signed [cpid_pkg::MUL_A_W-1:0] mul_a,
   input  logic signed [cpid_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [cpid_pkg::PROD_W-1:0]  prod
);

   logic signed [cpid_pkg::PROD_W-1:0] prod_ff;
   logic signed [cpid_pkg::PROD_W-1:0] prod_in;

   // one signed multiply, registered
   assign prod_in = cpid_pkg::PROD_W'(mul_a) * cpid_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/cpid_seq.sv =====
module cpid_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              out_free,
   output cpid_pkg::ctl_type ctl
);

   localparam logic [cpid_pkg::AXIS_W-1:0] LAST_AXIS =
      cpid_pkg::AXIS_W'(cpid_pkg::NUM_AXES - 1);

   cpid_pkg::step_type              state_ff, state_in;
   logic [cpid_pkg::AXIS_W-1:0]     axis_ff, axis_in;
   logic                            inner_ff, inner_in;

   // step through outer then inner loop of each axis
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      inner_in = inner_ff;
      unique case (state_ff)
         cpid_pkg::S_IDLE: begin
            if (start) begin
               state_in = cpid_pkg::S_ERR;
               axis_in  = '0;
               inner_in = 1'b0;
            end
         end
         cpid_pkg::S_ERR: state_in = cpid_pkg::S_MP;
         cpid_pkg::S_MP:  state_in = cpid_pkg::S_MI;
         cpid_pkg::S_MI:  state_in = cpid_pkg::S_MZ;
         cpid_pkg::S_MZ:  state_in = cpid_pkg::S_MQ;
         cpid_pkg::S_MQ:  state_in = cpid_pkg::S_MD;
         cpid_pkg::S_MD:  state_in = cpid_pkg::S_FIN;
         cpid_pkg::S_FIN: begin
            priority if (inner_ff && (axis_ff == LAST_AXIS)) begin
               state_in = cpid_pkg::S_POST;
            end else if (inner_ff) begin
               state_in = cpid_pkg::S_ERR;
               axis_in  = axis_ff + 1'b1;
               inner_in = 1'b0;
            end else begin
               state_in = cpid_pkg::S_ERR;
               inner_in = 1'b1;
            end
         end
         cpid_pkg::S_POST: begin
            if (out_free) begin
               state_in = cpid_pkg::S_IDLE;
            end
         end
         default: state_in = cpid_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpid_pkg::S_IDLE;
         axis_ff  <= '0;
         inner_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         inner_ff <= inner_in;
      end
   end

   assign ctl.step  = state_ff;
   assign ctl.axis  = axis_ff;
   assign ctl.inner = inner_ff;

endmodule

// ===== rtl/cascaded_attitude_rate_pid.sv =====
// Channel    Direction  Handshake            Payload
// req_       in         req_valid/req_ready  12 angles, rates, accels (Q5.12)
// rsp_       out        rsp_valid/rsp_ready  3 rate commands, 3 torques (Q5.12)
// csr_       in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Requests are taken only in idle: each runs six PID loops (steps ERR, MP, MI, MZ,
// MQ, MD, FIN), then a hand-off step that waits while a result is not yet taken,
// then idle. The single shared multiplier, used four times per loop, sets the pace.
// Reset clears the sequencer, accumulators, primed flag and result valid, and loads the configuration registers.
// A result not yet taken holds the next one in the hand-off step.
module cascaded_attitude_rate_pid (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [cpid_pkg::SIG_W-1:0]      req_roll_target,
   input  logic signed [cpid_pkg::SIG_W-1:0]      req_pitch_target,
   input  logic signed [cpid_pkg::SIG_W-1:0]      req_yaw_target,
   input  logic signed [cpid_pkg::SIG_W-1:0]      req_roll_angle,
   input  logic signed [cpid_pkg::SIG_W-1:0]      req_pitch_angle,
   input  logic signed [cpid_pkg::SIG_W-1:0]      req_yaw_angle,
   input  logic signed [cpid_pkg::SIG_W-1:0]      req_roll_rate,
   input  logic signed [cpid_pkg::SIG_W-1:0]      req_pitch_rate,
   input  logic signed [cpid_pkg::SIG_W-1:0]      req_yaw_rate,
   input  logic signed [cpid_pkg::SIG_W-1:0]      req_roll_accel,
   input  logic signed [cpid_pkg::SIG_W-1:0]      req_pitch_accel,
   input  logic signed [cpid_pkg::SIG_W-1:0]      req_yaw_accel,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [cpid_pkg::SIG_W-1:0]      rsp_roll_rate_cmd,
   output logic signed [cpid_pkg::SIG_W-1:0]      rsp_pitch_rate_cmd,
   output logic signed [cpid_pkg::SIG_W-1:0]      rsp_yaw_rate_cmd,
   output logic signed [cpid_pkg::SIG_W-1:0]      rsp_roll_torque,
   output logic signed [cpid_pkg::SIG_W-1:0]      rsp_pitch_torque,
   output logic signed [cpid_pkg::SIG_W-1:0]      rsp_yaw_torque,
   // register port
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cpid_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [cpid_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int SIG_W   = cpid_pkg::SIG_W;
   localparam int ERR_W   = cpid_pkg::ERR_W;
   localparam int MAG_W   = cpid_pkg::MAG_W;
   localparam int ACC_W   = cpid_pkg::ACC_W;
   localparam int GAIN_W  = cpid_pkg::GAIN_W;
   localparam int LIM_W   = cpid_pkg::LIM_W;
   localparam int SUM_W   = cpid_pkg::SUM_WIDTH;
   localparam int FRAC    = cpid_pkg::FRAC_BITS;
   localparam int A_W     = cpid_pkg::MUL_A_W;
   localparam int B_W     = cpid_pkg::MUL_B_W;
   localparam int P_W     = cpid_pkg::PROD_W;
   localparam int Y_W     = P_W - FRAC;
   localparam int Z_W     = cpid_pkg::Z_W;
   localparam int Q_W     = cpid_pkg::Q_W;
   localparam int N_AX    = cpid_pkg::NUM_AXES;

   localparam logic [cpid_pkg::AXIS_W-1:0] AX_ROLL  = cpid_pkg::AXIS_W'(0);
   localparam logic [cpid_pkg::AXIS_W-1:0] AX_PITCH = cpid_pkg::AXIS_W'(1);
   localparam logic [cpid_pkg::AXIS_W-1:0] AX_YAW   = cpid_pkg::AXIS_W'(2);

   localparam logic [MAG_W-1:0] WIN_TILT_V = MAG_W'(cpid_pkg::WIN_TILT);
   localparam logic [MAG_W-1:0] WIN_YAW_V  = MAG_W'(cpid_pkg::WIN_YAW);
   localparam logic [MAG_W-1:0] WIN_RATE_V = MAG_W'(cpid_pkg::WIN_RATE);
   localparam logic [LIM_W-1:0] RATE_BND_V = LIM_W'(cpid_pkg::RATE_BOUND);
   localparam logic signed [SIG_W-1:0] RATE_BND_S = SIG_W'(cpid_pkg::RATE_BOUND);
   localparam logic signed [Y_W-1:0]   Y_HI = Y_W'(cpid_pkg::ISAT);
   localparam logic signed [Y_W-1:0]   Y_LO = -Y_W'(cpid_pkg::ISAT);
   localparam logic [A_W-1:0]          MAGIC_V = A_W'(cpid_pkg::DIV_MAGIC);
   localparam logic signed [Q_W:0]     Q_OFS = (Q_W + 1)'(longint'(1) << (SIG_W - 1));

   // clamp to +-b
   function automatic logic signed [SIG_W-1:0] clamp_fn(
      input logic signed [ACC_W-1:0] v,
      input logic [LIM_W-1:0]        b
   );
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      logic signed [ACC_W-1:0] r;
      hi = $signed({{(ACC_W - LIM_W){1'b0}}, b});
      lo = -hi;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r[SIG_W-1:0];
   endfunction

   cpid_pkg::ctl_type ctl;

   logic req_accept;
   logic out_free;

   // request latches
   logic signed [SIG_W-1:0] tgt_ff   [N_AX];
   logic signed [SIG_W-1:0] ang_ff   [N_AX];
   logic signed [SIG_W-1:0] rate_ff  [N_AX];
   logic signed [SIG_W-1:0] accel_ff [N_AX];

   // configuration registers
   logic signed [GAIN_W-1:0] angle_kp_ff, angle_ki_ff, angle_kd_ff;
   logic signed [GAIN_W-1:0] rate_kp_ff, rate_ki_ff, rate_kd_ff;
   logic [LIM_W-1:0]         tilt_lim_ff, yaw_lim_ff;

   // loop state
   logic signed [SUM_W-1:0] asum_ff [N_AX];
   logic signed [SUM_W-1:0] rsum_ff [N_AX];
   logic                    primed_ff;

   // datapath
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [ACC_W-1:0] acc_ff;
   logic [Z_W-1:0]          z_ff, z_in;
   logic signed [SIG_W-1:0] cmd_ff [N_AX];
   logic signed [SIG_W-1:0] trq_ff [N_AX];

   logic signed [SIG_W-1:0] src_a, src_b, deriv;
   logic signed [GAIN_W-1:0] kp, ki, kd;
   logic [MAG_W-1:0]        win_sel;
   logic [LIM_W-1:0]        bound_sel;
   logic signed [SUM_W-1:0] cur_sum;
   logic signed [SUM_W:0]   sum_ext;
   logic signed [SUM_W-1:0] sum_in;
   logic signed [MAG_W-1:0] err_sx;
   logic [MAG_W-1:0]        err_mag;
   logic                    in_win;

   logic signed [A_W-1:0]   mul_a;
   logic signed [B_W-1:0]   mul_b;
   logic signed [P_W-1:0]   prod;

   logic signed [ACC_W-1:0] term_sh;
   logic signed [Y_W-1:0]   y_full, y_sat, z_full;
   logic [Q_W-1:0]          q_raw;
   logic signed [Q_W:0]     q_s;
   logic signed [SIG_W-1:0] ci;
   logic signed [ACC_W-1:0] tot;
   logic signed [SIG_W-1:0] out_in;

   logic                    rsp_valid_ff;
   logic signed [SIG_W-1:0] rsp_cmd_ff [N_AX];
   logic signed [SIG_W-1:0] rsp_trq_ff [N_AX];

   // sequencer
   cpid_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .out_free (out_free),
      .ctl      (ctl)
   );

   // shared multiplier
   cpid_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_ready  = (ctl.step == cpid_pkg::S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign csr_ready  = 1'b1;

   // latch request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         tgt_ff[AX_ROLL]    <= req_roll_target;
         tgt_ff[AX_PITCH]   <= req_pitch_target;
         tgt_ff[AX_YAW]     <= req_yaw_target;
         ang_ff[AX_ROLL]    <= req_roll_angle;
         ang_ff[AX_PITCH]   <= req_pitch_angle;
         ang_ff[AX_YAW]     <= req_yaw_angle;
         rate_ff[AX_ROLL]   <= req_roll_rate;
         rate_ff[AX_PITCH]  <= req_pitch_rate;
         rate_ff[AX_YAW]    <= req_yaw_rate;
         accel_ff[AX_ROLL]  <= req_roll_accel;
         accel_ff[AX_PITCH] <= req_pitch_accel;
         accel_ff[AX_YAW]   <= req_yaw_accel;
      end
   end

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_kp_ff <= cpid_pkg::RST_ANGLE_KP;
         angle_ki_ff <= cpid_pkg::RST_ANGLE_KI;
         angle_kd_ff <= cpid_pkg::RST_ANGLE_KD;
         rate_kp_ff  <= cpid_pkg::RST_RATE_KP;
         rate_ki_ff  <= cpid_pkg::RST_RATE_KI;
         rate_kd_ff  <= cpid_pkg::RST_RATE_KD;
         tilt_lim_ff <= cpid_pkg::RST_TILT_LIM;
         yaw_lim_ff  <= cpid_pkg::RST_YAW_LIM;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cpid_pkg::REG_ANGLE_KP: angle_kp_ff <= $signed(csr_wdata[GAIN_W-1:0]);
            cpid_pkg::REG_ANGLE_KI: angle_ki_ff <= $signed(csr_wdata[GAIN_W-1:0]);
            cpid_pkg::REG_ANGLE_KD: angle_kd_ff <= $signed(csr_wdata[GAIN_W-1:0]);
            cpid_pkg::REG_RATE_KP:  rate_kp_ff  <= $signed(csr_wdata[GAIN_W-1:0]);
            cpid_pkg::REG_RATE_KI:  rate_ki_ff  <= $signed(csr_wdata[GAIN_W-1:0]);
            cpid_pkg::REG_RATE_KD:  rate_kd_ff  <= $signed(csr_wdata[GAIN_W-1:0]);
            cpid_pkg::REG_TILT_LIM: tilt_lim_ff <= csr_wdata[LIM_W-1:0];
            cpid_pkg::REG_YAW_LIM:  yaw_lim_ff  <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // per-loop operand selection
   always_comb begin
      if (ctl.inner) begin
         src_a     = cmd_ff[ctl.axis];
         src_b     = rate_ff[ctl.axis];
         deriv     = accel_ff[ctl.axis];
         kp        = rate_kp_ff;
         ki        = rate_ki_ff;
         kd        = rate_kd_ff;
         win_sel   = WIN_RATE_V;
         bound_sel = (ctl.axis == AX_YAW) ? yaw_lim_ff : tilt_lim_ff;
         cur_sum   = rsum_ff[ctl.axis];
      end else begin
         src_a     = tgt_ff[ctl.axis];
         src_b     = ang_ff[ctl.axis];
         deriv     = rate_ff[ctl.axis];
         kp        = angle_kp_ff;
         ki        = angle_ki_ff;
         kd        = angle_kd_ff;
         win_sel   = (ctl.axis == AX_YAW) ? WIN_YAW_V : WIN_TILT_V;
         bound_sel = RATE_BND_V;
         cur_sum   = asum_ff[ctl.axis];
      end
   end

   // loop error
   assign err_in = {src_a[SIG_W-1], src_a} - {src_b[SIG_W-1], src_b};

   // window test and saturating accumulate
   assign err_sx  = {err_ff[ERR_W-1], err_ff};
   assign err_mag = err_ff[ERR_W-1] ? $unsigned(-err_sx) : $unsigned(err_sx);
   assign in_win  = (err_mag < win_sel);
   assign sum_ext = {cur_sum[SUM_W-1], cur_sum}
                  + {{(SUM_W + 1 - ERR_W){err_ff[ERR_W-1]}}, err_ff};
   always_comb begin
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
         sum_in = sum_ext[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                 : {1'b0, {(SUM_W - 1){1'b1}}};
      end else begin
         sum_in = sum_ext[SUM_W-1:0];
      end
   end

   // multiplier operands by step
   always_comb begin
      unique case (ctl.step)
         cpid_pkg::S_MP: begin
            mul_a = {{(A_W - GAIN_W){kp[GAIN_W-1]}}, kp};
            mul_b = {{(B_W - ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         cpid_pkg::S_MI: begin
            mul_a = {{(A_W - GAIN_W){ki[GAIN_W-1]}}, ki};
            mul_b = {cur_sum[SUM_W-1], cur_sum};
         end
         cpid_pkg::S_MQ: begin
            mul_a = MAGIC_V;
            mul_b = {{(B_W - Z_W){1'b0}}, z_ff};
         end
         cpid_pkg::S_MD: begin
            mul_a = {{(A_W - GAIN_W){kd[GAIN_W-1]}}, kd};
            mul_b = {{(B_W - SIG_W){deriv[SIG_W-1]}}, deriv};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // product scaled by 2^-FRAC, floor
   assign term_sh = prod[FRAC +: ACC_W];

   // integral: pre-saturate, offset to non-negative for the reciprocal divide
   assign y_full = prod[P_W-1:FRAC];
   always_comb begin
      if (y_full > Y_HI) begin
         y_sat = Y_HI;
      end else if (y_full < Y_LO) begin
         y_sat = Y_LO;
      end else begin
         y_sat = y_full;
      end
   end
   assign z_full = y_sat + Y_HI;
   assign z_in   = z_full[Z_W-1:0];

   // quotient back to signed, then clamp
   assign q_raw = prod[cpid_pkg::DIV_SHIFT +: Q_W];
   assign q_s   = $signed({1'b0, q_raw}) - Q_OFS;
   assign ci    = clamp_fn({{(ACC_W - Q_W - 1){q_s[Q_W]}}, q_s}, bound_sel);

   assign tot    = acc_ff + term_sh;
   assign out_in = clamp_fn(tot, bound_sel);

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (ctl.step)
         cpid_pkg::S_ERR: err_ff <= err_in;
         cpid_pkg::S_MI:  acc_ff <= term_sh;
         cpid_pkg::S_MZ:  z_ff   <= z_in;
         cpid_pkg::S_MD:  acc_ff <= acc_ff + {{(ACC_W - SIG_W){ci[SIG_W-1]}}, ci};
         cpid_pkg::S_FIN: begin
            if (ctl.inner) begin
               trq_ff[ctl.axis] <= out_in;
            end else begin
               cmd_ff[ctl.axis] <= out_in;
            end
         end
         default: ;
      endcase
   end

   // accumulators, cleared at reset and on the first request after it, else summed while in window
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         for (int i = 0; i < N_AX; i++) begin
            asum_ff[i] <= '0;
            rsum_ff[i] <= '0;
         end
      end else if (req_accept && !primed_ff) begin
         primed_ff <= 1'b1;
         for (int i = 0; i < N_AX; i++) begin
            asum_ff[i] <= '0;
            rsum_ff[i] <= '0;
         end
      end else if ((ctl.step == cpid_pkg::S_MP) && in_win) begin
         if (ctl.inner) begin
            rsum_ff[ctl.axis] <= sum_in;
         end else begin
            asum_ff[ctl.axis] <= sum_in;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((ctl.step == cpid_pkg::S_POST) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((ctl.step == cpid_pkg::S_POST) && out_free) begin
         for (int i = 0; i < N_AX; i++) begin
            rsp_cmd_ff[i] <= cmd_ff[i];
            rsp_trq_ff[i] <= trq_ff[i];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_roll_rate_cmd  = rsp_cmd_ff[AX_ROLL];
   assign rsp_pitch_rate_cmd = rsp_cmd_ff[AX_PITCH];
   assign rsp_yaw_rate_cmd   = rsp_cmd_ff[AX_YAW];
   assign rsp_roll_torque    = rsp_trq_ff[AX_ROLL];
   assign rsp_pitch_torque   = rsp_trq_ff[AX_PITCH];
   assign rsp_yaw_torque     = rsp_trq_ff[AX_YAW];

`ifndef SYNTHESIS
   a_start_roll_outer: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (ctl.step == cpid_pkg::S_ERR) && (ctl.axis == AX_ROLL) && !ctl.inner)
      else $error("request did not start at roll outer loop");

   a_last_loop_post: assert property (@(posedge clock) disable iff (reset)
      ((ctl.step == cpid_pkg::S_FIN) && ctl.inner && (ctl.axis == AX_YAW))
      |=> (ctl.step == cpid_pkg::S_POST))
      else $error("yaw inner loop not followed by hand-off");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      (ctl.step != cpid_pkg::S_IDLE) |-> (ctl.axis <= AX_YAW))
      else $error("axis counter out of range");

   a_cmd_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_rate_cmd <= RATE_BND_S) && (rsp_roll_rate_cmd >= -RATE_BND_S)
                 && (rsp_yaw_rate_cmd <= RATE_BND_S) && (rsp_yaw_rate_cmd >= -RATE_BND_S))
      else $error("rate command beyond bound");
`endif

endmodule
